// ----- hdl/zcdp_pkg.sv -----
// -----------------------------------------------------------------------------
// ZIP central directory parser package
// Shared word types, header field positions and constants of the parser.
// -----------------------------------------------------------------------------
package zcdp_pkg;

   // Fixed part of one central directory record, in bytes.
   localparam int unsigned HdrBytes = 46;
   localparam logic [31:0] CdirSig  = 32'h0201_4B50;

   // Byte positions of the captured header fields.
   localparam int unsigned SigLastPos     = 3;
   localparam int unsigned MethodPos      = 10;
   localparam int unsigned ChecksumPos    = 16;
   localparam int unsigned PackedPos      = 20;
   localparam int unsigned UnpackedPos    = 24;
   localparam int unsigned NameLenPos     = 28;
   localparam int unsigned ExtraLenPos    = 30;
   localparam int unsigned CommentLenPos  = 32;
   localparam int unsigned OffsetPos      = 42;

   localparam int unsigned PosBits        = 18;
   localparam int unsigned QueueDepthDflt = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [15:0] entry_index;
      logic [15:0] method_code;
      logic [31:0] expected_checksum;
      logic [31:0] packed_size;
      logic [31:0] unpacked_size;
      logic [31:0] local_header_position;
      logic [15:0] name_bytes;
      logic        status;
      logic        final_entry;
   } rsp_type;

   // Result event passed from the front to the back through the queue.
   typedef struct packed {
      logic [15:0] idx;
      logic        err;
      logic        fin;
      logic [15:0] method;
      logic [31:0] checksum;
      logic [31:0] packed_sz;
      logic [31:0] unpacked_sz;
      logic [31:0] offset;
      logic [15:0] name_len;
   } evt_type;

endpackage

// ----- hdl/zcdp_front.sv -----
// -----------------------------------------------------------------------------
// ZIP central directory parser front end
// Takes stream bytes, captures header fields, tracks record position and
// raises entry or error events.
// -----------------------------------------------------------------------------
module zcdp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  zcdp_pkg::req_type req_data,
   input  logic             csr_write,
   input  logic [15:0]      csr_data,
   output logic             evt_push,
   output zcdp_pkg::evt_type evt_data
);
   import zcdp_pkg::*;

   logic [PosBits-1:0] pos_ff, pos_in;
   logic [31:0]        sig_ff, sig_in;
   logic [15:0]        method_ff, method_in;
   logic [31:0]        checksum_ff, checksum_in;
   logic [31:0]        packed_ff, packed_in;
   logic [31:0]        unpacked_ff, unpacked_in;
   logic [15:0]        name_len_ff, name_len_in;
   logic [15:0]        extra_len_ff, extra_len_in;
   logic [15:0]        comment_len_ff, comment_len_in;
   logic [31:0]        offset_ff, offset_in;
   logic [15:0]        done_ff, done_in;
   logic               stopped_ff, stopped_in;
   logic [15:0]        expected_ff;

   logic               active;
   logic [PosBits:0]   pos_inc;
   logic [PosBits:0]   rec_size;
   logic               fin;
   logic [1:0]         lane4;
   logic [1:0]         off_lane;
   logic               lane2;
   logic [7:0]         b;

   assign b        = req_data.data_byte;
   assign active   = req_valid && !req_stall && !stopped_ff && (done_ff < expected_ff);
   assign pos_inc  = {1'b0, pos_ff} + (PosBits+1)'(1);
   assign rec_size = (PosBits+1)'(HdrBytes) + (PosBits+1)'(name_len_ff)
                   + (PosBits+1)'(extra_len_ff) + (PosBits+1)'(comment_len_ff);
   assign fin      = ({1'b0, done_ff} + 17'd1) >= {1'b0, expected_ff};
   assign lane4    = pos_ff[1:0];
   assign lane2    = pos_ff[0];
   // The offset field starts at a position that is 2 modulo 4.
   assign off_lane = pos_ff[1:0] - 2'd2;

   always_comb begin
      pos_in         = pos_ff;
      sig_in         = sig_ff;
      method_in      = method_ff;
      checksum_in    = checksum_ff;
      packed_in      = packed_ff;
      unpacked_in    = unpacked_ff;
      name_len_in    = name_len_ff;
      extra_len_in   = extra_len_ff;
      comment_len_in = comment_len_ff;
      offset_in      = offset_ff;
      done_in        = done_ff;
      stopped_in     = stopped_ff;
      evt_push       = 1'b0;
      evt_data       = '0;

      if (active) begin
         if (pos_ff <= PosBits'(SigLastPos)) begin
            sig_in[{lane4, 3'b000} +: 8] = b;
         end else if (pos_ff >= PosBits'(MethodPos) && pos_ff < PosBits'(MethodPos + 2)) begin
            method_in[{lane2, 3'b000} +: 8] = b;
         end else if (pos_ff >= PosBits'(ChecksumPos) && pos_ff < PosBits'(PackedPos)) begin
            checksum_in[{lane4, 3'b000} +: 8] = b;
         end else if (pos_ff >= PosBits'(PackedPos) && pos_ff < PosBits'(UnpackedPos)) begin
            packed_in[{lane4, 3'b000} +: 8] = b;
         end else if (pos_ff >= PosBits'(UnpackedPos) && pos_ff < PosBits'(NameLenPos)) begin
            unpacked_in[{lane4, 3'b000} +: 8] = b;
         end else if (pos_ff >= PosBits'(NameLenPos) && pos_ff < PosBits'(ExtraLenPos)) begin
            name_len_in[{lane2, 3'b000} +: 8] = b;
         end else if (pos_ff >= PosBits'(ExtraLenPos) && pos_ff < PosBits'(CommentLenPos)) begin
            extra_len_in[{lane2, 3'b000} +: 8] = b;
         end else if (pos_ff >= PosBits'(CommentLenPos)
                      && pos_ff < PosBits'(CommentLenPos + 2)) begin
            comment_len_in[{lane2, 3'b000} +: 8] = b;
         end else if (pos_ff >= PosBits'(OffsetPos) && pos_ff < PosBits'(HdrBytes)) begin
            offset_in[{off_lane, 3'b000} +: 8] = b;
         end

         evt_data.method      = method_in;
         evt_data.checksum    = checksum_in;
         evt_data.packed_sz   = packed_in;
         evt_data.unpacked_sz = unpacked_in;
         evt_data.offset      = offset_in;
         evt_data.name_len    = name_len_in;
         evt_data.idx         = done_ff;

         if (pos_ff == PosBits'(SigLastPos) && sig_in != CdirSig) begin
            // Bad signature: report and stop at once.
            stopped_in   = 1'b1;
            evt_push     = 1'b1;
            evt_data.err = 1'b1;
            evt_data.fin = 1'b1;
         end else if (pos_inc >= rec_size) begin
            // Last byte of the record (record size is never below the header).
            pos_in   = '0;
            evt_push = 1'b1;
            if (req_data.end_of_data && !fin) begin
               stopped_in   = 1'b1;
               evt_data.err = 1'b1;
               evt_data.fin = 1'b1;
            end else begin
               done_in      = done_ff + 16'd1;
               evt_data.fin = fin;
            end
         end else begin
            pos_in = pos_inc[PosBits-1:0];
            if (req_data.end_of_data) begin
               stopped_in   = 1'b1;
               evt_push     = 1'b1;
               evt_data.err = 1'b1;
               evt_data.fin = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         sig_ff         <= '0;
         method_ff      <= '0;
         checksum_ff    <= '0;
         packed_ff      <= '0;
         unpacked_ff    <= '0;
         name_len_ff    <= '0;
         extra_len_ff   <= '0;
         comment_len_ff <= '0;
         offset_ff      <= '0;
         done_ff        <= '0;
         stopped_ff     <= 1'b0;
         expected_ff    <= '0;
      end else begin
         pos_ff         <= pos_in;
         sig_ff         <= sig_in;
         method_ff      <= method_in;
         checksum_ff    <= checksum_in;
         packed_ff      <= packed_in;
         unpacked_ff    <= unpacked_in;
         name_len_ff    <= name_len_in;
         extra_len_ff   <= extra_len_in;
         comment_len_ff <= comment_len_in;
         offset_ff      <= offset_in;
         done_ff        <= done_in;
         stopped_ff     <= stopped_in;
         if (csr_write) begin
            expected_ff <= csr_data;
         end
      end
   end

endmodule

// ----- hdl/zcdp_queue.sv -----
// -----------------------------------------------------------------------------
// ZIP central directory parser event queue
// Small first-in first-out store of result events between front and back.
// -----------------------------------------------------------------------------
module zcdp_queue #(
   parameter int unsigned DEPTH = zcdp_pkg::QueueDepthDflt
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  zcdp_pkg::evt_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output zcdp_pkg::evt_type head
);
   import zcdp_pkg::*;

   localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntBits = $clog2(DEPTH + 1);

   evt_type              slot_ff [DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CntBits'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/zcdp_back.sv -----
// -----------------------------------------------------------------------------
// ZIP central directory parser back end
// Turns queued events into result words and holds them in the output register.
// -----------------------------------------------------------------------------
module zcdp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              evt_avail,
   input  zcdp_pkg::evt_type evt_head,
   output logic              evt_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output zcdp_pkg::rsp_type rsp_data
);
   import zcdp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic    load;

   // The output register takes a new word when it is empty or being drained.
   assign load    = !valid_ff || !rsp_stall;
   assign evt_pop = load && evt_avail;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in                      = evt_avail;
         data_in.entry_index           = evt_head.idx;
         data_in.status                = evt_head.err;
         data_in.final_entry           = evt_head.fin;
         // An error word carries only its index and flags.
         data_in.method_code           = evt_head.err ? '0 : evt_head.method;
         data_in.expected_checksum     = evt_head.err ? '0 : evt_head.checksum;
         data_in.packed_size           = evt_head.err ? '0 : evt_head.packed_sz;
         data_in.unpacked_size         = evt_head.err ? '0 : evt_head.unpacked_sz;
         data_in.local_header_position = evt_head.err ? '0 : evt_head.offset;
         data_in.name_bytes            = evt_head.err ? '0 : evt_head.name_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- hdl/zip_central_directory_parser.sv -----
// -----------------------------------------------------------------------------
// ZIP central directory parser
// Walks the central directory records of a ZIP archive and reports one word
// per record, or one error word when the directory is corrupt or truncated.
// -----------------------------------------------------------------------------
// The parser takes one directory byte per clock cycle while the queue is not
// full, back to back, starting at the first central directory record. The
// front end checks each record's signature, captures the little-endian header
// fields in place as the bytes go by, and skips the name, extra and comment
// bytes; the record's end is found by comparing the byte position against the
// header size plus the three captured lengths. Each finished record, or a
// failure, becomes an event in a short queue (QUEUE_DEPTH entries), and the
// back end turns events into result words in an output register. A result
// word reaches rsp_data after it passes through the queue and then the output
// register, and the input keeps taking bytes while a word waits to be taken;
// the input stalls only when the queue is full. Program entries_expected
// through the csr port before streaming; with zero entries, or after the last
// entry or an error, bytes are taken and dropped. An error word has status
// set, final_entry set, the failing record's index, and zero in all captured
// fields.
module zip_central_directory_parser #(
   parameter int unsigned QUEUE_DEPTH = zcdp_pkg::QueueDepthDflt
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  zcdp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output zcdp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);
   import zcdp_pkg::*;

   logic    evt_push;
   evt_type evt_data;
   logic    q_full;
   logic    q_not_empty;
   evt_type q_head;
   logic    q_pop;

   // The single register is always writable.
   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   zcdp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .evt_push  (evt_push),
      .evt_data  (evt_data)
   );

   zcdp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_data (evt_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   zcdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .evt_avail (q_not_empty),
      .evt_head  (q_head),
      .evt_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
